### rtl/mqrb_pkg.sv
// Shared types and codes for the multi-queue ring buffer.
// Used by mqrb_ctrl, mqrb_datapath and multi_queue_ring_buffer; no dependencies.
package mqrb_pkg;

  localparam int NUM_QUEUES_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 256;

  // command codes
  localparam logic [2:0] CMD_CREATE  = 3'd0;
  localparam logic [2:0] CMD_DESTROY = 3'd1;
  localparam logic [2:0] CMD_PUSH    = 3'd2;
  localparam logic [2:0] CMD_POP     = 3'd3;
  localparam logic [2:0] CMD_PEEK    = 3'd4;
  localparam logic [2:0] CMD_STATUS  = 3'd5;

  // result status codes
  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_BAD_HANDLE = 3'd1;
  localparam logic [2:0] STS_INACTIVE   = 3'd2;
  localparam logic [2:0] STS_FULL       = 3'd3;
  localparam logic [2:0] STS_EMPTY      = 3'd4;
  localparam logic [2:0] STS_BAD_CAP    = 3'd5;
  localparam logic [2:0] STS_NO_SLOT    = 3'd6;

  typedef struct packed {
    logic [2:0]         command;
    logic [7:0]         handle;
    logic signed [63:0] value;
    logic [16:0]        capacity_request;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [63:0] data;
    logic [8:0]         count;
    logic [8:0]         queue_capacity;
    logic               full_res;
    logic               empty_res;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_COMMIT,
    S_RESPOND
  } state_t;

  // one strobe per sequencing step, controller to datapath
  typedef struct packed {
    logic capture;
    logic decide;
    logic commit;
    logic respond;
  } ctrl_cmd_t;

endpackage

### rtl/mqrb_ctrl.sv
// Sequencer for the multi-queue ring buffer: capture, fetch/decide, commit, respond.
// Depends on mqrb_pkg (state_t, ctrl_cmd_t).
module mqrb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output mqrb_pkg::ctrl_cmd_t ctrl
);
  import mqrb_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_FETCH;
      end
      S_FETCH:   state_nxt = S_COMMIT;
      S_COMMIT:  state_nxt = S_RESPOND;
      S_RESPOND: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy         = 1'b1;
    ctrl.capture = 1'b0;
    ctrl.decide  = 1'b0;
    ctrl.commit  = 1'b0;
    ctrl.respond = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        busy         = 1'b0;
        ctrl.capture = start;
      end
      S_FETCH:   ctrl.decide  = 1'b1;
      S_COMMIT:  ctrl.commit  = 1'b1;
      S_RESPOND: ctrl.respond = 1'b1;
      default:   busy         = 1'b1;
    endcase
  end

endmodule

### rtl/mqrb_datapath.sv
// Datapath of the multi-queue ring buffer: descriptor table, active bits, free-slot
// search, word store and result register. Depends on mqrb_pkg; driven by mqrb_ctrl.
module mqrb_datapath #(
  parameter int NUM_QUEUES  = mqrb_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqrb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mqrb_pkg::ctrl_cmd_t ctrl,
  input  mqrb_pkg::in_item_t  in_item,
  output mqrb_pkg::out_item_t out_item,
  output logic                out_strobe
);
  import mqrb_pkg::*;

  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int WORDS = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int G   = 16;
  localparam int GW  = 4;
  localparam int NG  = (NUM_QUEUES + G - 1) / G;

  typedef struct packed {
    logic [PW-1:0] rp;
    logic [PW-1:0] wp;
    logic [CW-1:0] cnt;
    logic [CW-1:0] cap;
  } desc_t;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] ptr,
                                            input logic [CW-1:0] cap);
    logic [CW:0] nxt;
    nxt = (CW+1)'(ptr) + (CW+1)'(1);
    return (nxt >= (CW+1)'(cap)) ? '0 : PW'(nxt);
  endfunction

  // storage
  desc_t       desc_mem [NUM_QUEUES];
  logic [63:0] word_mem [WORDS];
  logic [NUM_QUEUES-1:0] active_r;

  // captured command and registered reads
  in_item_t    item_r;
  desc_t       desc_q_r;
  logic [63:0] word_q_r;

  // first level of the free-slot search, one entry per group of slots
  logic [NG-1:0] grp_found_r;
  logic [GW-1:0] grp_idx_r [NG];
  logic [NG-1:0] grp_found_nxt;
  logic [GW-1:0] grp_idx_nxt [NG];

  // decision registers
  logic [2:0]    status_r,    status_nxt;
  logic [63:0]   data_r,      data_nxt;
  logic          use_word_r,  use_word_nxt;
  logic          we_word_r,   we_word_nxt;
  logic          re_word_r,   re_word_nxt;
  logic [AW-1:0] word_addr_r, word_addr_nxt;
  logic          desc_we_r,   desc_we_nxt;
  logic [QW-1:0] slot_r,      slot_nxt;
  desc_t         desc_wd_r,   desc_wd_nxt;
  logic          act_set_r,   act_set_nxt;
  logic          act_clr_r,   act_clr_nxt;
  logic [8:0]    cnt_o_r,     cnt_o_nxt;
  logic [8:0]    cap_o_r,     cap_o_nxt;
  logic          full_o_r,    full_o_nxt;
  logic          empty_o_r,   empty_o_nxt;

  out_item_t out_r;
  logic      out_strobe_r;

  always_comb begin
    logic [G*NG-1:0] free_pad;
    for (int i = 0; i < G * NG; i++) begin
      free_pad[i] = (i < NUM_QUEUES) ? !active_r[i] : 1'b0;
    end
    for (int g = 0; g < NG; g++) begin
      grp_found_nxt[g] = 1'b0;
      grp_idx_nxt[g]   = '0;
      for (int j = G - 1; j >= 0; j--) begin
        if (free_pad[g*G + j]) begin
          grp_found_nxt[g] = 1'b1;
          grp_idx_nxt[g]   = GW'(j);
        end
      end
    end
  end

  // capture the command, read its descriptor, register the group search
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      item_r   <= in_item;
      desc_q_r <= desc_mem[in_item.handle[QW-1:0]];
      for (int g = 0; g < NG; g++) begin
        grp_found_r[g] <= grp_found_nxt[g];
        grp_idx_r[g]   <= grp_idx_nxt[g];
      end
    end
  end

  // decide the outcome from the captured command and descriptor
  always_comb begin
    logic          free_found;
    logic [QW-1:0] free_idx;
    logic [QW-1:0] hq;
    logic          hvalid;
    logic          hact;
    logic          q_act;
    logic [CW-1:0] q_cnt;
    logic [CW-1:0] q_cap;
    desc_t         d;

    free_found = 1'b0;
    free_idx   = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_found_r[g]) begin
        free_found = 1'b1;
        free_idx   = QW'(g * G) + QW'(grp_idx_r[g]);
      end
    end

    hq     = item_r.handle[QW-1:0];
    hvalid = ({1'b0, item_r.handle} < 9'(NUM_QUEUES));
    hact   = hvalid && active_r[hq];
    d      = desc_q_r;

    status_nxt    = STS_OK;
    data_nxt      = '0;
    use_word_nxt  = 1'b0;
    we_word_nxt   = 1'b0;
    re_word_nxt   = 1'b0;
    word_addr_nxt = '0;
    desc_we_nxt   = 1'b0;
    slot_nxt      = hq;
    desc_wd_nxt   = d;
    act_set_nxt   = 1'b0;
    act_clr_nxt   = 1'b0;
    q_act         = 1'b0;
    q_cnt         = d.cnt;
    q_cap         = d.cap;

    if (item_r.command == CMD_CREATE) begin
      if (item_r.capacity_request == '0 ||
          item_r.capacity_request > 17'(QUEUE_DEPTH)) begin
        status_nxt = STS_BAD_CAP;
        data_nxt   = '1;
      end else if (!free_found) begin
        status_nxt = STS_NO_SLOT;
        data_nxt   = '1;
      end else begin
        slot_nxt    = free_idx;
        act_set_nxt = 1'b1;
        desc_we_nxt = 1'b1;
        desc_wd_nxt = '{rp: '0, wp: '0, cnt: '0, cap: CW'(item_r.capacity_request)};
        data_nxt    = 64'(free_idx);
        q_act       = 1'b1;
        q_cnt       = '0;
        q_cap       = CW'(item_r.capacity_request);
      end
    end else if (!hvalid) begin
      status_nxt = STS_BAD_HANDLE;
      data_nxt   = '1;
    end else if (!hact) begin
      status_nxt = STS_INACTIVE;
      data_nxt   = '1;
    end else begin
      q_act = 1'b1;
      case (item_r.command)
        CMD_DESTROY: begin
          act_clr_nxt = 1'b1;
          q_act       = 1'b0;
        end
        CMD_PUSH: begin
          if (d.cnt >= d.cap) begin
            status_nxt = STS_FULL;
            data_nxt   = '1;
          end else begin
            we_word_nxt    = 1'b1;
            word_addr_nxt  = AW'(hq) * AW'(QUEUE_DEPTH) + AW'(d.wp);
            desc_we_nxt    = 1'b1;
            desc_wd_nxt.wp = advance(d.wp, d.cap);
            desc_wd_nxt.cnt = d.cnt + CW'(1);
            q_cnt          = d.cnt + CW'(1);
          end
        end
        CMD_POP, CMD_PEEK: begin
          if (d.cnt == '0) begin
            status_nxt = STS_EMPTY;
            data_nxt   = '1;
          end else begin
            re_word_nxt   = 1'b1;
            use_word_nxt  = 1'b1;
            word_addr_nxt = AW'(hq) * AW'(QUEUE_DEPTH) + AW'(d.rp);
            if (item_r.command == CMD_POP) begin
              desc_we_nxt     = 1'b1;
              desc_wd_nxt.rp  = advance(d.rp, d.cap);
              desc_wd_nxt.cnt = d.cnt - CW'(1);
              q_cnt           = d.cnt - CW'(1);
            end
          end
        end
        default: begin
          // status query, also the unused codes
        end
      endcase
    end

    if (q_act) begin
      cnt_o_nxt   = 9'(q_cnt);
      cap_o_nxt   = 9'(q_cap);
      full_o_nxt  = (q_cnt >= q_cap);
      empty_o_nxt = (q_cnt == '0);
    end else begin
      cnt_o_nxt   = '0;
      cap_o_nxt   = '0;
      full_o_nxt  = 1'b0;
      empty_o_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.decide) begin
      status_r    <= status_nxt;
      data_r      <= data_nxt;
      use_word_r  <= use_word_nxt;
      we_word_r   <= we_word_nxt;
      re_word_r   <= re_word_nxt;
      word_addr_r <= word_addr_nxt;
      desc_we_r   <= desc_we_nxt;
      slot_r      <= slot_nxt;
      desc_wd_r   <= desc_wd_nxt;
      act_set_r   <= act_set_nxt;
      act_clr_r   <= act_clr_nxt;
      cnt_o_r     <= cnt_o_nxt;
      cap_o_r     <= cap_o_nxt;
      full_o_r    <= full_o_nxt;
      empty_o_r   <= empty_o_nxt;
    end
  end

  // commit: descriptor write, word store access
  always_ff @(posedge clk) begin
    if (ctrl.commit && desc_we_r) begin
      desc_mem[slot_r] <= desc_wd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit && we_word_r) begin
      word_mem[word_addr_r] <= item_r.value;
    end
    if (ctrl.commit && re_word_r) begin
      word_q_r <= word_mem[word_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (ctrl.commit) begin
      if (act_set_r) active_r[slot_r] <= 1'b1;
      if (act_clr_r) active_r[slot_r] <= 1'b0;
    end
  end

  // respond: form the result beat, shown for one cycle
  always_ff @(posedge clk) begin
    if (ctrl.respond) begin
      out_r.status         <= status_r;
      out_r.data           <= use_word_r ? word_q_r : data_r;
      out_r.count          <= cnt_o_r;
      out_r.queue_capacity <= cap_o_r;
      out_r.full_res       <= full_o_r;
      out_r.empty_res      <= empty_o_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctrl.respond;
    end
  end

  assign out_item   = out_r;
  assign out_strobe = out_strobe_r;

endmodule

### rtl/multi_queue_ring_buffer.sv
// Top level of the multi-queue ring buffer: sequencer plus datapath.
// Depends on mqrb_pkg, mqrb_ctrl and mqrb_datapath.
//
// A command is taken when start is high and busy is low; busy then stays high
// until the result beat appears on out_item with out_strobe high for exactly one
// cycle. The receiver cannot stall, so it must take every beat in its strobe
// cycle. A new command may be offered in that same strobe cycle. The sequencer
// reads the queue descriptor table on capture, decides on fetch (including the
// second level of the lowest-free-slot search), accesses the word store on
// commit and registers the result on respond. Create ignores the handle field.
// No clearing pass is needed after reset: the active bits reset at once and gate
// every table entry.
module multi_queue_ring_buffer #(
  parameter int NUM_QUEUES  = mqrb_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqrb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mqrb_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output mqrb_pkg::out_item_t out_item
);
  import mqrb_pkg::*;

  ctrl_cmd_t ctrl;

  mqrb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  mqrb_datapath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_item    (in_item),
    .out_item   (out_item),
    .out_strobe (out_strobe)
  );

endmodule
